// ===== hdl/sun_pkg.sv =====
`default_nettype none

package sun_pkg;

    // Default capacity of the sorted store.
    localparam int DEPTH_DEFAULT = 16;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Width of a kept value: the sign bit is dropped.
    localparam int VALUE_W = 31;

    // Width of the input value and of the output data bus.
    localparam int DATA_W = 32;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               keep;   // non-negative, to be inserted
        logic               last;   // closes the set
    } item_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/sun_front.sv =====
`default_nettype none

module sun_front
    import sun_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    output logic                   q_push,
    output item_t                  q_item,
    input  wire logic              q_ready
);

    logic  hold_valid_reg, hold_valid_next;
    item_t hold_reg, hold_next;
    item_t cls;
    logic  accept, useful;

    // A negative value that does not close the set carries no work and is
    // dropped here; everything else is held for the queue.
    always_comb begin
        cls.value = s_tdata[VALUE_W-1:0];
        cls.keep  = ~s_tdata[DATA_W-1];
        cls.last  = s_tlast;
    end

    assign useful   = cls.keep | cls.last;
    assign q_push   = hold_valid_reg & q_ready;
    assign q_item   = hold_reg;
    assign s_tready = ~hold_valid_reg | q_ready;
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        hold_valid_next = (hold_valid_reg & ~q_push) | (accept & useful);
        hold_next       = (accept & useful) ? cls : hold_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

// ===== hdl/sun_queue.sv =====
`default_nettype none

module sun_queue
    import sun_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_en,
    input  wire item_t wr_item,
    output logic       wr_ready,
    input  wire logic  rd_en,
    output item_t      rd_item,
    output logic       rd_valid
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign wr_ready = cnt_reg != CNT_FULL;
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en & wr_ready;
    assign do_rd    = rd_en & rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sun_back.sv =====
`default_nettype none

module sun_back
    import sun_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire item_t             q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [VALUE_W-1:0] cell_reg  [DEPTH];
    logic [VALUE_W-1:0] cell_next [DEPTH];
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    back_state_t        state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg, out_none_reg, out_ovf_reg;

    logic [DEPTH-1:0]   lt, eq;
    logic               dup, full, do_ins, do_ovf, emit, empty, final_res;

    // Each cell compares its value with the incoming one; the store is
    // ascending, so the cells below the new value form a prefix.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt[i] = (CW'(i) < count_reg) && (cell_reg[i] < q_item.value);
            eq[i] = (CW'(i) < count_reg) && (cell_reg[i] == q_item.value);
        end
    end

    assign dup       = |eq;
    assign full      = count_reg == CNT_FULL;
    assign empty     = count_reg == '0;
    assign final_res = count_reg <= CW'(1);
    assign q_pop     = q_valid && (state_reg == ST_FILL);
    assign do_ins    = q_pop && q_item.keep && !dup && !full;
    assign do_ovf    = q_pop && q_item.keep && !dup && full;
    assign emit      = (state_reg == ST_DRAIN) && (!out_valid_reg || m_tready);

    // Insertion shifts the cells at and above the slot up by one; each emitted
    // result shifts the store down by one.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
        end
        if (do_ins) begin
            if (!lt[0]) begin
                cell_next[0] = q_item.value;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!lt[i]) begin
                    cell_next[i] = lt[i-1] ? q_item.value : cell_reg[i-1];
                end
            end
        end else if (emit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (do_ins) begin
                    count_next = count_reg + CW'(1);
                end
                if (do_ovf) begin
                    ovf_next = 1'b1;
                end
                if (q_pop && q_item.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (emit) begin
                    if (!empty) begin
                        count_next = count_reg - CW'(1);
                    end
                    if (final_res) begin
                        ovf_next   = 1'b0;
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    assign out_valid_next = emit | (out_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            state_reg     <= ST_FILL;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        for (int i = 0; i < DEPTH; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        if (emit) begin
            out_value_reg <= empty ? '0 : cell_reg[0];
            out_last_reg  <= final_res;
            out_none_reg  <= empty;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W - VALUE_W){1'b0}}, out_value_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_none_reg};

endmodule

`default_nettype wire

// ===== hdl/sort_unique_nonnegative.sv =====
`default_nettype none

// Sorts one set of signed 32-bit values and returns its distinct non-negative
// members in strictly increasing order. Each request on the slave side carries
// one value; tlast marks the last value of the set. Negative values are
// ignored and repeated values are kept once. When the set closes, the block
// returns one request per kept value, with tlast on the largest one. A set
// that kept nothing returns a single request with zero data, tlast set and the
// empty flag in tuser. The store holds DEPTH values; a new distinct value that
// arrives while it is full is dropped and the overflow flag in tuser is raised
// on every request of that set. The store is empty again after each set.
// Timing: while a set is being collected, the insertion chain takes one value
// per clock. Once the closing value has reached the back end, the drain of the
// store sends its results out, paced by m_tready. During the drain the front
// keeps taking values into its holding register and a small queue, and
// s_tready drops only once those are full. The closing value passes from the
// holding register through the queue, behind any values still waiting there,
// to the back end, which enters the drain state; the first result is then
// registered onto m_tvalid.
module sort_unique_nonnegative
    import sun_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input requests.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value (two's complement)
    input  wire logic              s_tlast,   // closes the set
    // Results.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [30:0] sorted_value, [31] zero
    output logic                   m_tlast,   // last result of the set
    output logic [1:0]             m_tuser    // [0] none_kept, [1] overflowed
);

    logic  f_push, f_ready;
    item_t f_item;
    logic  b_valid, b_pop;
    item_t b_item;

    // The front classifies each value and holds it for the queue.
    sun_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (f_push),
        .q_item   (f_item),
        .q_ready  (f_ready)
    );

    // The queue lets the front keep accepting while the back drains a set.
    sun_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (f_push),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_en    (b_pop),
        .rd_item  (b_item),
        .rd_valid (b_valid)
    );

    // The back holds the sorted store and sends out the results.
    sun_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_item   (b_item),
        .q_pop    (b_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An empty-set result is always the only and therefore last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty-set result without tlast");

    // An empty-set result carries zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty-set result with nonzero data");

    // Within a set, the next result follows at once and is strictly larger.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[VALUE_W-1:0] > $past(m_tdata[VALUE_W-1:0]))))
        else $error("results of a set not strictly increasing");

endmodule

`default_nettype wire

// ===== dv/sort_unique_nonnegative_test.sv =====
`default_nettype none

// Checks sort_unique_nonnegative against a behavioral copy of its sorted
// store. A driver block offers requests from a queue, and a monitor block
// compares every result request with the oldest predicted one.
module sort_unique_nonnegative_test
    import sun_pkg::*;
();

    localparam int          STORE_DEPTH  = DEPTH_DEFAULT;
    localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN      = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE    = 32'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS = 300;
    localparam int          IDLE_PCT     = 28;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          TAIL_CYCLES  = 20;

    // One input request: a value and the flag that closes the set.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              set_end;
    } value_req_t;

    // One result request as the block should return it.
    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               final_res;
        logic               none_kept;
        logic               overflowed;
    } sorted_res_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    sort_unique_nonnegative dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    value_req_t  pending_values[$];
    sorted_res_t expected_sorted[$];

    // Predicted contents of the store for the set now being collected.
    logic [VALUE_W-1:0] kept_values[STORE_DEPTH];
    int                 kept_total    = 0;
    logic               overflow_flag = 1'b0;

    int error_count     = 0;
    int results_seen    = 0;
    int requests_taken  = 0;
    int sets_closed     = 0;
    int empty_sets      = 0;
    int overflow_sets   = 0;
    int random_sent     = 0;
    int cycle_count     = 0;
    int stall_cycles    = 0;
    int backpressure    = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    bit random_phase    = 1'b0;

    // Both sides stop idling inside this window of cycles.
    function automatic bit quiet_window(input int cyc);
        return cyc >= 600 && cyc < 900;
    endfunction

    // Inserts one accepted value into the predicted store and, when it closes
    // the set, queues the results that the drain should produce.
    task automatic absorb_value(input value_req_t req);
        logic [VALUE_W-1:0] v;
        int                 pos;
        bit                 dup;
        sorted_res_t        res;
        if (!req.value[DATA_W-1]) begin
            v   = req.value[VALUE_W-1:0];
            pos = 0;
            while (pos < kept_total && kept_values[pos] < v) pos++;
            dup = (pos < kept_total) && (kept_values[pos] == v);
            if (!dup) begin
                if (kept_total >= STORE_DEPTH) begin
                    // The store is full: the new value is lost.
                    overflow_flag = 1'b1;
                end else begin
                    for (int k = kept_total; k > pos; k--) kept_values[k] = kept_values[k-1];
                    kept_values[pos] = v;
                    kept_total++;
                end
            end
        end
        if (req.set_end) begin
            sets_closed++;
            if (overflow_flag) overflow_sets++;
            if (kept_total == 0) begin
                empty_sets++;
                res.sorted_value = '0;
                res.final_res    = 1'b1;
                res.none_kept    = 1'b1;
                res.overflowed   = overflow_flag;
                expected_sorted  = {expected_sorted, res};
            end else begin
                for (int k = 0; k < kept_total; k++) begin
                    res.sorted_value = kept_values[k];
                    res.final_res    = (k + 1 == kept_total);
                    res.none_kept    = 1'b0;
                    res.overflowed   = overflow_flag;
                    expected_sorted  = {expected_sorted, res};
                end
            end
            kept_total    = 0;
            overflow_flag = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch on result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic add_value(input logic [DATA_W-1:0] value, input bit set_end);
        value_req_t req;
        req.value      = value;
        req.set_end    = set_end;
        pending_values = {pending_values, req};
        if (random_phase) random_sent++;
    endtask

    // Draws one value, mixing narrow ranges (for repeats), extremes and
    // full-width words.
    function automatic logic [DATA_W-1:0] draw_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return $urandom_range(0, 15);
        if (sel < 65) return $urandom;
        if (sel < 75) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return INT_MAX;
                2: return MINUS_ONE;
                default: return INT_MIN;
            endcase
        end
        return {1'b0, 31'($urandom_range(0, INT_MAX))};
    endfunction

    // A set of count distinct values in scrambled order, with a few negative
    // and repeated values mixed in. Counts above the store depth overflow it.
    task automatic queue_distinct_set(input int count);
        int                key;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] stride;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] prev;
        key    = $urandom_range(0, 31);
        stride = $urandom_range(1, 1 << 20);
        base   = $urandom_range(0, 1 << 30);
        prev   = base;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 12)
                add_value({1'b1, 31'($urandom_range(0, INT_MAX))}, 1'b0);
            if (i > 0 && $urandom_range(0, 99) < 10) add_value(prev, 1'b0);
            v = base + (i ^ key) * stride;
            add_value(v, i == count - 1);
            prev = v;
        end
    endtask

    task automatic queue_plain_set(input int count);
        for (int i = 0; i < count; i++) add_value(draw_value(), i == count - 1);
    endtask

    // Driver: offers pending requests, holding each one until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_value(pending_values[0]);
                void'(pending_values.pop_front());
                requests_taken++;
            end
            if (s_tvalid && !s_tready) begin
                backpressure++;
            end else if (pending_values.size() > 0 &&
                         (quiet_window(cycle_count) || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_values[0].value;
                s_tlast  <= pending_values[0].set_end;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result and paces m_tready, with one long
    // hold-off while the block is draining so that its input backs up.
    always @(posedge aclk) begin
        sorted_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sorted.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data %h", m_tdata));
                end else begin
                    want = expected_sorted.pop_front();
                    if (m_tdata[DATA_W-1:VALUE_W] != '0)
                        report_mismatch("upper data bit is not zero");
                    if (m_tdata[VALUE_W-1:0] != want.sorted_value)
                        report_mismatch($sformatf("sorted_value %h, predicted %h",
                                                  m_tdata[VALUE_W-1:0], want.sorted_value));
                    if (m_tlast != want.final_res)
                        report_mismatch($sformatf("final_res %b, predicted %b",
                                                  m_tlast, want.final_res));
                    if (m_tuser[0] != want.none_kept)
                        report_mismatch($sformatf("none_kept %b, predicted %b",
                                                  m_tuser[0], want.none_kept));
                    if (m_tuser[1] != want.overflowed)
                        report_mismatch($sformatf("overflowed %b, predicted %b",
                                                  m_tuser[1], want.overflowed));
                end
                results_seen++;
            end
            if (!hold_done && m_tvalid && results_seen >= 40) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= quiet_window(cycle_count) || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Counts cycles in which neither side moves a request.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int sel;
        // Extremes, negative values and a repeated value.
        add_value(32'd5, 1'b0);
        add_value(INT_MAX, 1'b0);
        add_value(32'd0, 1'b0);
        add_value(32'd5, 1'b0);
        add_value(MINUS_ONE, 1'b0);
        add_value(INT_MIN, 1'b0);
        add_value(32'd3, 1'b1);
        // Sets that keep nothing.
        add_value(MINUS_ONE, 1'b0);
        add_value(INT_MIN, 1'b1);
        add_value(-32'sd5, 1'b1);
        // Single-value sets at both ends of the range.
        add_value(32'd0, 1'b1);
        add_value(INT_MAX, 1'b1);
        // The closing value is negative, so only the earlier one is kept.
        add_value(32'd7, 1'b0);
        add_value(32'd7, 1'b0);
        add_value(-32'sd2, 1'b1);
        // A repeat on the closing value.
        add_value(32'd9, 1'b0);
        add_value(32'd9, 1'b1);
        // Alternating bit patterns.
        add_value(32'h5555_5555, 1'b0);
        add_value(32'h2AAA_AAAA, 1'b1);
        add_value(32'hAAAA_AAAA, 1'b1);

        random_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                queue_distinct_set($urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8));
            else if (sel < 18)
                queue_distinct_set(STORE_DEPTH);
            else
                queue_plain_set($urandom_range(1, 8));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_values.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_sorted.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_sorted.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_sorted.size()));

        $display("Sent %0d requests in %0d sets; checked %0d results (%0d empty, %0d overflowed).",
                 requests_taken, sets_closed, results_seen, empty_sets, overflow_sets);
        $display("Receiver held off %0d cycles once; input was stalled in %0d cycles.",
                 HOLD_CYCLES, backpressure);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
